// ===== rtl/qsht_pkg.sv =====
`timescale 1ns / 1ps

package qsht_pkg;

	// field widths
	localparam int COORD_W = 30;
	localparam int LEVEL_W = 5;
	localparam int VALUE_W = 64;
	localparam int CFG_IDX_W = 3;

	// deepest level that the step shift honours
	localparam int MAX_DEPTH = 29;

	// item operations, carried in tuser
	typedef enum logic [1:0] {
		OP_TEST    = 2'd0,
		OP_ENTER   = 2'd1,
		OP_LEAVE   = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_START_X  = 3'd0,
		CFG_LINE_START_Y  = 3'd1,
		CFG_LINE_END_X    = 3'd2,
		CFG_LINE_END_Y    = 3'd3,
		CFG_ROOT_ORIGIN_X = 3'd4,
		CFG_ROOT_ORIGIN_Y = 3'd5,
		CFG_ROOT_WIDTH    = 3'd6,
		CFG_UNUSED        = 3'd7
	} cfg_idx_t;

endpackage

// ===== rtl/quadtree_square_halfplane_test_unit.sv =====
`timescale 1ns / 1ps

// Quadtree square versus directed line test. Each input word carries an
// operation in tuser (test child, enter child, leave to parent, restart at
// root) and the child selection and level in tdata; each one gives exactly
// one result word with all_hit and any_hit. One word is taken per cycle
// while the result side does not stall. Its result enters the output
// register on the edge at which the word leaves the input register. The
// edge values and steps live in registers; the edge values are updated by
// a three-input 64-bit add behind a 64-bit arithmetic shift of the steps,
// and the steps are loaded on a restart. The root values come from six
// signed multipliers (up to 31 by 33 bits) that run off the configuration
// registers and are registered every cycle, so a restart may follow a
// configuration write in the very next cycle.
module quadtree_square_halfplane_test_unit
	import qsht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	// input words
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // go_right, go_down, level[4:0], zero pad
	input  logic [1:0]           s_tuser,   // operation
	// result words
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata    // all_hit, any_hit, zero pad
);

	localparam logic [LEVEL_W-1:0] MAX_LVL = LEVEL_W'(MAX_DEPTH);

	// configuration registers
	logic signed [COORD_W-1:0] line_start_x_q, line_start_y_q;
	logic signed [COORD_W-1:0] line_end_x_q, line_end_y_q;
	logic signed [COORD_W-1:0] root_origin_x_q, root_origin_y_q;
	logic        [COORD_W-1:0] root_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_x_q  <= '0;
			line_start_y_q  <= '0;
			line_end_x_q    <= '0;
			line_end_y_q    <= '0;
			root_origin_x_q <= '0;
			root_origin_y_q <= '0;
			root_width_q    <= COORD_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LINE_START_X:  line_start_x_q  <= cfg_data;
				CFG_LINE_START_Y:  line_start_y_q  <= cfg_data;
				CFG_LINE_END_X:    line_end_x_q    <= cfg_data;
				CFG_LINE_END_Y:    line_end_y_q    <= cfg_data;
				CFG_ROOT_ORIGIN_X: root_origin_x_q <= cfg_data;
				CFG_ROOT_ORIGIN_Y: root_origin_y_q <= cfg_data;
				CFG_ROOT_WIDTH:    root_width_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// line deltas, normal signs and corner offsets of the root square
	logic signed [COORD_W:0]   dx, dy, wid;
	logic signed [COORD_W+1:0] ndy;
	logic                      pre_nxn, pre_nyn;
	logic signed [COORD_W+2:0] ox_lo, ox_hi, oy_lo, oy_hi;
	logic signed [COORD_W+2:0] near_x, far_x, near_y, far_y;

	always_comb begin
		dx      = (COORD_W+1)'(line_end_x_q) - (COORD_W+1)'(line_start_x_q);
		dy      = (COORD_W+1)'(line_end_y_q) - (COORD_W+1)'(line_start_y_q);
		wid     = $signed({1'b0, root_width_q});
		ndy     = -((COORD_W+2)'(dy));
		pre_nxn = !dy[COORD_W];
		// minus dx is non-negative exactly when dx is not positive
		pre_nyn = dx[COORD_W] || (dx == '0);
		ox_lo   = (COORD_W+3)'(root_origin_x_q) - (COORD_W+3)'(line_start_x_q);
		ox_hi   = ox_lo + (COORD_W+3)'(wid);
		oy_lo   = (COORD_W+3)'(root_origin_y_q) - (COORD_W+3)'(line_start_y_q);
		oy_hi   = oy_lo + (COORD_W+3)'(wid);
		near_x  = pre_nxn ? ox_lo : ox_hi;
		far_x   = pre_nxn ? ox_hi : ox_lo;
		near_y  = pre_nyn ? oy_lo : oy_hi;
		far_y   = pre_nyn ? oy_hi : oy_lo;
	end

	// root products, registered every cycle from the configuration
	logic signed [VALUE_W-1:0] near_dxy_q, near_dyx_q, far_dxy_q, far_dyx_q;
	logic signed [VALUE_W-1:0] xstep_pre_q, ystep_pre_q;
	logic                      nxn_pre_q, nyn_pre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_dxy_q  <= '0;
			near_dyx_q  <= '0;
			far_dxy_q   <= '0;
			far_dyx_q   <= '0;
			xstep_pre_q <= '0;
			ystep_pre_q <= '0;
			nxn_pre_q   <= 1'b1;
			nyn_pre_q   <= 1'b1;
		end else begin
			near_dxy_q  <= VALUE_W'(dx) * VALUE_W'(near_y);
			near_dyx_q  <= VALUE_W'(dy) * VALUE_W'(near_x);
			far_dxy_q   <= VALUE_W'(dx) * VALUE_W'(far_y);
			far_dyx_q   <= VALUE_W'(dy) * VALUE_W'(far_x);
			xstep_pre_q <= VALUE_W'(ndy) * VALUE_W'(wid);
			ystep_pre_q <= VALUE_W'(dx) * VALUE_W'(wid);
			nxn_pre_q   <= pre_nxn;
			nyn_pre_q   <= pre_nyn;
		end
	end

	// input register
	logic               s1_valid;
	op_t                s1_op;
	logic               s1_right, s1_down;
	logic [LEVEL_W-1:0] s1_level;
	logic               out_valid_s2;
	logic               out_complete_s2, out_partial_s2;
	logic               adv;

	assign adv      = s1_valid && (!out_valid_s2 || m_tready);
	assign s_tready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_op    <= op_t'(s_tuser);
			s1_right <= s_tdata[0];
			s1_down  <= s_tdata[1];
			s1_level <= s_tdata[2 +: LEVEL_W];
		end
	end

	// traversal state
	logic signed [VALUE_W-1:0] near_q, far_q, xstep_q, ystep_q;
	logic                      nxn_q, nyn_q;

	// child move or parent undo, and restart values
	logic [LEVEL_W-1:0]        lvl;
	logic signed [VALUE_W-1:0] sx, sy, tx, ty;
	logic                      undo, x_near, y_near;
	logic signed [VALUE_W-1:0] mv_near, mv_far, nv, fv;

	always_comb begin
		lvl     = (s1_level > MAX_LVL) ? MAX_LVL : s1_level;
		sx      = xstep_q >>> lvl;
		sy      = ystep_q >>> lvl;
		undo    = (s1_op == OP_LEAVE);
		tx      = (s1_right ^ undo) ? sx : -sx;
		ty      = (s1_down ^ undo) ? sy : -sy;
		x_near  = !(s1_right ^ nxn_q);
		y_near  = !(s1_down ^ nyn_q);
		mv_near = near_q + (x_near ? tx : '0) + (y_near ? ty : '0);
		mv_far  = far_q + (x_near ? '0 : tx) + (y_near ? '0 : ty);
		if (s1_op == OP_RESTART) begin
			nv = near_dxy_q - near_dyx_q;
			fv = far_dxy_q - far_dyx_q;
		end else begin
			nv = mv_near;
			fv = mv_far;
		end
	end

	// state commit for enter, leave and restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q  <= '0;
			far_q   <= '0;
			xstep_q <= '0;
			ystep_q <= '0;
			nxn_q   <= 1'b0;
			nyn_q   <= 1'b0;
		end else if (adv && s1_op != OP_TEST) begin
			near_q <= nv;
			far_q  <= fv;
			if (s1_op == OP_RESTART) begin
				xstep_q <= xstep_pre_q;
				ystep_q <= ystep_pre_q;
				nxn_q   <= nxn_pre_q;
				nyn_q   <= nyn_pre_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_complete_s2 <= nv[VALUE_W-1];
			out_partial_s2  <= fv[VALUE_W-1] || (fv == '0);
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {6'b0, out_partial_s2, out_complete_s2};

`ifndef SYNTHESIS
	// input side only stalls while a word waits in the input register
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid)
		else $error("input stalled with empty input register");

	// every word that leaves the input register shows up as a result
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("advanced word produced no result");

	// a test leaves the traversal state untouched
	a_test_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s1_op == OP_TEST) |=> ($stable(near_q) && $stable(far_q)))
		else $error("test item changed edge values");

	// a restart loads the steps from the root products
	a_restart_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s1_op == OP_RESTART) |=> (xstep_q == $past(xstep_pre_q)
			&& ystep_q == $past(ystep_pre_q)))
		else $error("restart did not load steps");
`endif

endmodule

// ===== tb/halfplane_hit_checker.sv =====
`timescale 1ns / 1ps

module halfplane_hit_checker
	import qsht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,   // go_right, go_down, level[4:0], zero pad
	input  logic [1:0]           s_tuser,   // operation
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [7:0]           m_tdata,   // all_hit, any_hit, zero pad
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic all_hit;
		logic any_hit;
	} hit_flags_t;

	// shadow of the configuration registers
	logic [COORD_W-1:0] reg_shadow [0:6];

	// predicted traversal state
	logic [VALUE_W-1:0] near_val;
	logic [VALUE_W-1:0] far_val;
	logic [VALUE_W-1:0] x_step;
	logic [VALUE_W-1:0] y_step;
	logic               nrm_x_pos;
	logic               nrm_y_pos;

	hit_flags_t expected_hits [$];

	function automatic logic [VALUE_W-1:0] shifted_step(logic [VALUE_W-1:0] v,
			int unsigned sh);
		return $signed(v) >>> sh;
	endfunction

	// one child move, or its undo when undo is set
	function automatic void apply_child_move(inout logic [VALUE_W-1:0] nv,
			inout logic [VALUE_W-1:0] fv, input logic right, input logic down,
			input int unsigned lvl, input logic undo);
		logic [VALUE_W-1:0] sx;
		logic [VALUE_W-1:0] sy;
		sx = shifted_step(x_step, lvl);
		sy = shifted_step(y_step, lvl);
		if (undo) begin
			sx = 64'd0 - sx;
			sy = 64'd0 - sy;
		end
		if (right) begin
			if (nrm_x_pos) nv = nv + sx;
			else fv = fv + sx;
		end else begin
			if (nrm_x_pos) fv = fv - sx;
			else nv = nv - sx;
		end
		if (down) begin
			if (nrm_y_pos) nv = nv + sy;
			else fv = fv + sy;
		end else begin
			if (nrm_y_pos) fv = fv - sy;
			else nv = nv - sy;
		end
	endfunction

	// edge values at the root corners and the full-width steps
	task automatic restart_at_root();
		longint x1, y1, x2, y2, ox, oy, w, dx, dy, ndx, nx, ny, fx, fy;
		x1 = longint'($signed(reg_shadow[CFG_LINE_START_X]));
		y1 = longint'($signed(reg_shadow[CFG_LINE_START_Y]));
		x2 = longint'($signed(reg_shadow[CFG_LINE_END_X]));
		y2 = longint'($signed(reg_shadow[CFG_LINE_END_Y]));
		ox = longint'($signed(reg_shadow[CFG_ROOT_ORIGIN_X]));
		oy = longint'($signed(reg_shadow[CFG_ROOT_ORIGIN_Y]));
		w = {34'd0, reg_shadow[CFG_ROOT_WIDTH]};
		dx = x2 - x1;
		dy = y2 - y1;
		ndx = 64'sd0 - dx;
		nrm_x_pos = !dy[63];
		nrm_y_pos = !ndx[63];
		nx = (nrm_x_pos ? ox : ox + w) - x1;
		fx = (nrm_x_pos ? ox + w : ox) - x1;
		ny = (nrm_y_pos ? oy : oy + w) - y1;
		fy = (nrm_y_pos ? oy + w : oy) - y1;
		near_val = dx * ny - dy * nx;
		far_val = dx * fy - dy * fx;
		x_step = (64'sd0 - dy) * w;
		y_step = dx * w;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		op_t                op;
		logic               right;
		logic               down;
		int unsigned        lvl;
		logic [VALUE_W-1:0] nv;
		logic [VALUE_W-1:0] fv;
		hit_flags_t         exp_hit;
		hit_flags_t         got_hit;
		if (!arst_n) begin
			for (int i = 0; i < 7; i++) reg_shadow[i] = '0;
			reg_shadow[CFG_ROOT_WIDTH] = 30'd1;
			near_val = '0;
			far_val = '0;
			x_step = '0;
			y_step = '0;
			nrm_x_pos = 1'b0;
			nrm_y_pos = 1'b0;
			expected_hits.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result word against the oldest prediction
			if (m_tvalid && m_tready) begin
				got_hit.all_hit = m_tdata[0];
				got_hit.any_hit = m_tdata[1];
				if (expected_hits.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: all %0b any %0b",
							got_hit.all_hit, got_hit.any_hit);
				end else begin
					exp_hit = expected_hits.pop_front();
					if (got_hit.all_hit !== exp_hit.all_hit ||
							got_hit.any_hit !== exp_hit.any_hit) begin
						fail_count++;
						if (fail_count <= 10)
							$display("hit mismatch: all exp %0b got %0b, any exp %0b got %0b",
								exp_hit.all_hit, got_hit.all_hit,
								exp_hit.any_hit, got_hit.any_hit);
					end
				end
			end
			// predict the flags of an accepted input word
			if (s_tvalid && s_tready) begin
				op = op_t'(s_tuser);
				right = s_tdata[0];
				down = s_tdata[1];
				lvl = 32'(s_tdata[6:2]);
				if (lvl > MAX_DEPTH) lvl = MAX_DEPTH;
				case (op)
					OP_RESTART: begin
						restart_at_root();
						nv = near_val;
						fv = far_val;
					end
					OP_LEAVE: begin
						apply_child_move(near_val, far_val, right, down, lvl, 1'b1);
						nv = near_val;
						fv = far_val;
					end
					default: begin
						nv = near_val;
						fv = far_val;
						apply_child_move(nv, fv, right, down, lvl, 1'b0);
						if (op == OP_ENTER) begin
							near_val = nv;
							far_val = fv;
						end
					end
				endcase
				exp_hit.all_hit = nv[63];
				exp_hit.any_hit = fv[63] || (fv == 64'd0);
				expected_hits.push_back(exp_hit);
			end
			// register writes take effect for later words
			if (cfg_we && cfg_index != CFG_UNUSED)
				reg_shadow[cfg_index] = cfg_data;
			pending = expected_hits.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
	import qsht_pkg::*;
();

	localparam logic [COORD_W-1:0] COORD_MIN = 30'h2000_0000;
	localparam logic [COORD_W-1:0] COORD_MAX = 30'h1FFF_FFFF;
	localparam logic [COORD_W-1:0] WIDTH_MAX = 30'h2000_0000;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 75;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;   // go_right, go_down, level[4:0], zero pad
	logic [1:0]           s_tuser = '0;   // operation
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;        // all_hit, any_hit, zero pad

	logic s_fire = 1'b0;
	logic stall_en = 1'b1;
	int   fail_count;
	int   pending;
	int   quiet_cycles = 0;

	quadtree_square_halfplane_test_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	halfplane_hit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// input handshake seen at the rising edge
	always @(posedge clk) s_fire <= s_tvalid && s_tready;

	// result side back-pressure
	always @(negedge clk) m_tready <= !(stall_en && ($urandom_range(99) < 6));

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic logic [COORD_W-1:0] to_coord(int v);
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		if ($urandom_range(3) == 0) return to_coord($urandom_range(2000) - 1000);
		return COORD_W'($urandom);
	endfunction

	function automatic logic [COORD_W-1:0] extreme_coord();
		return $urandom_range(1) ? COORD_MAX : COORD_MIN;
	endfunction

	// one input word, called at a falling edge; valid stays high on return
	task automatic send_word(op_t op, logic right, logic down, logic [4:0] lvl);
		while (stall_en && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, lvl, down, right};
		do @(negedge clk); while (!s_fire);
	endtask

	// all seven registers, written once the block has drained
	task automatic load_setup(logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
			logic [COORD_W-1:0] x2, logic [COORD_W-1:0] y2,
			logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy, logic [COORD_W-1:0] w);
		logic [COORD_W-1:0] vals [0:6];
		vals[CFG_LINE_START_X] = x1;
		vals[CFG_LINE_START_Y] = y1;
		vals[CFG_LINE_END_X] = x2;
		vals[CFG_LINE_END_Y] = y2;
		vals[CFG_ROOT_ORIGIN_X] = ox;
		vals[CFG_ROOT_ORIGIN_Y] = oy;
		vals[CFG_ROOT_WIDTH] = w;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed descent and ascent, some noise words
	task automatic run_traversal(int count);
		logic [1:0] quad_stk [0:MAX_DEPTH];
		int depth;
		int r;
		logic [1:0] q;
		depth = 0;
		send_word(OP_RESTART, 1'b0, 1'b0, 5'd0);
		for (int n = 1; n < count; n++) begin
			r = $urandom_range(99);
			q = 2'($urandom_range(3));
			if (r < 10) begin
				send_word(op_t'($urandom_range(3)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 5'($urandom_range(31)));
			end else if (r < 13) begin
				send_word(OP_RESTART, q[0], q[1], 5'($urandom_range(31)));
				depth = 0;
			end else if (r < 50) begin
				send_word(OP_TEST, q[0], q[1], 5'(depth + 1));
			end else if (r < 78 && depth < MAX_DEPTH) begin
				quad_stk[depth] = q;
				send_word(OP_ENTER, q[0], q[1], 5'(depth + 1));
				depth++;
			end else if (depth > 0) begin
				depth--;
				send_word(OP_LEAVE, quad_stk[depth][0], quad_stk[depth][1], 5'(depth + 1));
			end else begin
				send_word(OP_TEST, q[0], q[1], 5'd1);
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset state before any restart, degenerate line
		send_word(OP_TEST, 1'b0, 1'b0, 5'd1);
		send_word(OP_LEAVE, 1'b1, 1'b1, 5'd1);
		send_word(OP_ENTER, 1'b1, 1'b0, 5'd2);
		send_word(OP_RESTART, 1'b0, 1'b0, 5'd0);
		send_word(OP_TEST, 1'b1, 1'b1, 5'd1);

		// extreme coordinates and widest root, all quadrants and odd levels
		load_setup(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
			WIDTH_MAX);
		send_word(OP_RESTART, 1'b0, 1'b0, 5'd0);
		for (int i = 0; i < 4; i++) send_word(OP_TEST, i[0], i[1], 5'd1);
		send_word(OP_ENTER, 1'b1, 1'b1, 5'd1);
		send_word(OP_TEST, 1'b0, 1'b1, 5'd29);
		send_word(OP_TEST, 1'b1, 1'b0, 5'd30);
		send_word(OP_TEST, 1'b0, 1'b0, 5'd31);
		send_word(OP_TEST, 1'b1, 1'b1, 5'd0);
		send_word(OP_LEAVE, 1'b1, 1'b1, 5'd1);

		// opposite direction, zero width
		load_setup(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, '0);
		send_word(OP_RESTART, 1'b0, 1'b0, 5'd0);
		send_word(OP_ENTER, 1'b0, 1'b1, 5'd1);
		send_word(OP_LEAVE, 1'b0, 1'b1, 5'd1);

		// width that is not a power of two
		load_setup(to_coord(5), to_coord(-7), to_coord(-300), to_coord(40), to_coord(-64),
			to_coord(32), to_coord(12345));
		send_word(OP_RESTART, 1'b0, 1'b0, 5'd0);
		send_word(OP_TEST, 1'b1, 1'b0, 5'd2);
		send_word(OP_ENTER, 1'b0, 1'b0, 5'd1);

		// degenerate line away from the origin, unit width
		load_setup(to_coord(123), to_coord(-456), to_coord(123), to_coord(-456),
			to_coord(100), to_coord(-500), to_coord(1));
		send_word(OP_RESTART, 1'b0, 1'b0, 5'd0);
		send_word(OP_TEST, 1'b1, 1'b1, 5'd1);

		// random phases, the first two at the coordinate extremes
		for (int p = 0; p < PHASES; p++) begin
			if (p < 2)
				load_setup(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
					extreme_coord(), extreme_coord(), (p == 0) ? WIDTH_MAX : to_coord(1));
			else
				load_setup(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), to_coord(1 << $urandom_range(29)));
			stall_en = !(p == 5 || p == 6);
			run_traversal(WORDS_PER_PHASE);
		end
		stall_en = 1'b1;

		// drain and verdict
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
